[rtl/vtv_pkg.sv]
package vtv_pkg;

  // Item commands.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_COMBINE = 2'd1;
  localparam logic [1:0] CMD_VERTEX  = 2'd2;

  // Matrix code that selects no source matrix.
  localparam logic [1:0] MAT_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ORG_X  = 3'd0;
  localparam logic [2:0] CFG_ORG_Y  = 3'd1;
  localparam logic [2:0] CFG_SIZE_W = 3'd2;
  localparam logic [2:0] CFG_SIZE_H = 3'd3;
  localparam logic [2:0] CFG_EPS    = 3'd4;

  // Screen offset math: the scale magnitude is split at this bit for the
  // shared multiplier, and the offset is clamped to this limit.
  localparam int unsigned MS_SPLIT  = 20;
  localparam int unsigned OFF_LIMIT = 1048576;
  localparam int unsigned OFF_W     = 21;

  typedef enum logic [1:0] {
    OPA_SRC = 2'd0,
    OPA_PRD = 2'd1,
    OPA_MAG = 2'd2
  } opa_t;

  typedef enum logic [2:0] {
    OPB_SRC  = 3'd0,
    OPB_PRD  = 3'd1,
    OPB_POS  = 3'd2,
    OPB_MSHI = 3'd3,
    OPB_MSLO = 3'd4
  } opb_t;

  typedef enum logic [1:0] {
    DST_PRD = 2'd0,
    DST_VEC = 2'd1,
    DST_PH  = 2'd2,
    DST_PL  = 2'd3
  } dst_t;

  // One multiply issue; it travels down the multiply pipeline as a tag.
  typedef struct packed {
    logic       valid;
    opa_t       opa;
    opb_t       opb;
    logic       first;
    logic       last;
    dst_t       dst;
    logic [4:0] idx;
    logic [1:0] k;
  } mac_t;

  typedef struct packed {
    logic       take;
    logic       clr_we;
    logic [5:0] clr_addr;
    logic       src_load;
    mac_t       mac;
    logic [5:0] ra0;
    logic [5:0] ra1;
    logic       set_wz;
    logic       div_start;
    logic [1:0] div_sel;
    logic       ndc_wr;
    logic       scr_sum;
    logic       scr_fin;
    logic       coord;
    logic       out_load;
  } ctrl_t;

  typedef struct packed {
    logic w_zero;
    logic div_done;
  } status_t;

endpackage

[rtl/vtv_ram.sv]
module vtv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[rtl/vtv_div.sv]
module vtv_div #(
  parameter int NUM_W = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [31:0]        den,
  input  logic               neg,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem;
  logic [NUM_W-1:0] qsh;
  logic [31:0]      den_q;
  logic             neg_q;
  logic [32:0]      shifted;
  logic             ge;
  logic [32:0]      diff;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem, qsh[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      qsh   <= num;
      den_q <= den;
      neg_q <= neg;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : shifted[31:0];
      qsh <= {qsh[NUM_W-2:0], ge};
    end
  end

  always_comb begin
    if (neg_q) begin
      if ((|qsh[NUM_W-1:32]) || (qsh[31] && (|qsh[30:0]))) begin
        quo = 32'sh8000_0000;
      end else begin
        quo = -$signed(qsh[31:0]);
      end
    end else begin
      if (|qsh[NUM_W-1:31]) begin
        quo = 32'sh7FFF_FFFF;
      end else begin
        quo = $signed(qsh[31:0]);
      end
    end
  end

endmodule

[rtl/vtv_datapath.sv]
module vtv_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          matrix_id,
  input  logic [3:0]          coef_index,
  input  logic signed [31:0]  coef_value,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  pos_w,
  input  vtv_pkg::ctrl_t      ctrl,
  output vtv_pkg::status_t    status,
  output logic signed [31:0]  eye_x,
  output logic signed [31:0]  eye_y,
  output logic signed [31:0]  eye_z,
  output logic signed [31:0]  eye_w,
  output logic signed [31:0]  ndc_x,
  output logic signed [31:0]  ndc_y,
  output logic signed [31:0]  ndc_z,
  output logic signed [15:0]  screen_x,
  output logic signed [15:0]  screen_y,
  output logic                w_zero
);

  localparam int DIV_W   = 32 + FRAC_BITS;
  localparam int SCALE_W = 17 + FRAC_BITS;
  localparam int OFF_K   = 2 * FRAC_BITS + 1;
  localparam int SUM_W   = 66 + vtv_pkg::MS_SPLIT + 1;
  localparam logic signed [32:0] ONE_A = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  // Configuration.
  logic signed [15:0] org [2];
  logic [15:0]        size [2];
  logic [15:0]        eps;

  // Item registers and working results.
  logic [1:0]         id_q;
  logic [3:0]         idx_q;
  logic signed [31:0] coef_q;
  logic signed [31:0] pos_q [4];
  logic signed [31:0] vec [8];
  logic signed [31:0] ndc [3];
  logic signed [15:0] scr [2];
  logic               wz;

  // Memories.
  logic               src_we;
  logic [5:0]         src_wa;
  logic [31:0]        src_wd;
  logic [31:0]        src_rd0, src_rd1;
  logic               prd_we;
  logic [4:0]         prd_wa;
  logic [31:0]        prd_wd;
  logic [31:0]        prd_rd0, prd_rd1;

  // Multiply pipeline.
  vtv_pkg::mac_t      s1, s2;
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod, shifted, acc, acc_sum;
  logic signed [31:0] acc_sat;
  logic [65:0]        ph, pl;

  // Screen mapping.
  logic signed [32:0]        a_val [2];
  logic signed [SCALE_W-1:0] s_val [2];
  logic [31:0]               mag_a [2];
  logic [SCALE_W-1:0]        mag_s [2];
  logic                      neg [2];
  logic [SUM_W-1:0]          off_x, q_full;
  logic [vtv_pkg::OFF_W-1:0] off_q;
  logic signed [vtv_pkg::OFF_W:0] off_t;
  logic signed [22:0]        scr_sum;
  logic signed [15:0]        scr_sat;

  // Divider.
  logic signed [31:0] div_num_s, clip_w;
  logic [31:0]        div_num_m, div_den_m;
  logic               div_done;
  logic signed [31:0] div_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0]  <= '0;
      org[1]  <= '0;
      size[0] <= 16'd1;
      size[1] <= 16'd1;
      eps     <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vtv_pkg::CFG_ORG_X:  org[0]  <= cfg_data;
        vtv_pkg::CFG_ORG_Y:  org[1]  <= cfg_data;
        vtv_pkg::CFG_SIZE_W: size[0] <= cfg_data;
        vtv_pkg::CFG_SIZE_H: size[1] <= cfg_data;
        vtv_pkg::CFG_EPS:    eps     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      id_q     <= matrix_id;
      idx_q    <= coef_index;
      coef_q   <= coef_value;
      pos_q[0] <= pos_x;
      pos_q[1] <= pos_y;
      pos_q[2] <= pos_z;
      pos_q[3] <= pos_w;
    end
  end

  assign src_we = ctrl.clr_we | ctrl.src_load;
  assign src_wa = ctrl.clr_we ? ctrl.clr_addr : {id_q, idx_q};
  assign src_wd = ctrl.clr_we ? 32'd0 : coef_q;

  vtv_ram #(.WIDTH(32), .DEPTH(48)) u_src_ram (
    .clk    (clk),
    .we     (src_we),
    .waddr  (src_wa),
    .wdata  (src_wd),
    .raddr0 (ctrl.ra0),
    .raddr1 (ctrl.ra1),
    .rdata0 (src_rd0),
    .rdata1 (src_rd1)
  );

  assign prd_we = (ctrl.clr_we & ~ctrl.clr_addr[5])
                | (s2.valid & s2.last & (s2.dst == vtv_pkg::DST_PRD));
  assign prd_wa = ctrl.clr_we ? ctrl.clr_addr[4:0] : s2.idx;
  assign prd_wd = ctrl.clr_we ? 32'd0 : acc_sat;

  vtv_ram #(.WIDTH(32), .DEPTH(32)) u_prd_ram (
    .clk    (clk),
    .we     (prd_we),
    .waddr  (prd_wa),
    .wdata  (prd_wd),
    .raddr0 (ctrl.ra0[4:0]),
    .raddr1 (ctrl.ra1[4:0]),
    .rdata0 (prd_rd0),
    .rdata1 (prd_rd1)
  );

  for (genvar c = 0; c < 2; c++) begin : g_scale
    assign a_val[c] = $signed({ndc[c][31], ndc[c]}) + ONE_A;
    assign s_val[c] = $signed({1'b0, size[c], {FRAC_BITS{1'b0}}})
                    - $signed(SCALE_W'(eps));
    assign neg[c]   = a_val[c][32] ^ s_val[c][SCALE_W-1];
    assign mag_a[c] = a_val[c][32] ? 32'(-a_val[c]) : a_val[c][31:0];
    assign mag_s[c] = s_val[c][SCALE_W-1] ? SCALE_W'(-s_val[c]) : s_val[c];
  end

  // Stage 1: operands arrive with the registered memory reads.
  always_comb begin
    unique case (s1.opa)
      vtv_pkg::OPA_SRC: op_a = $signed({src_rd0[31], src_rd0});
      vtv_pkg::OPA_PRD: op_a = $signed({prd_rd0[31], prd_rd0});
      vtv_pkg::OPA_MAG: op_a = $signed({1'b0, mag_a[s1.k[0]]});
      default:          op_a = '0;
    endcase
    unique case (s1.opb)
      vtv_pkg::OPB_SRC:  op_b = $signed({src_rd1[31], src_rd1});
      vtv_pkg::OPB_PRD:  op_b = $signed({prd_rd1[31], prd_rd1});
      vtv_pkg::OPB_POS:  op_b = $signed({pos_q[s1.k][31], pos_q[s1.k]});
      vtv_pkg::OPB_MSHI: op_b = $signed(33'(mag_s[s1.k[0]] >> vtv_pkg::MS_SPLIT));
      vtv_pkg::OPB_MSLO: op_b = $signed({13'd0, mag_s[s1.k[0]][vtv_pkg::MS_SPLIT-1:0]});
      default:           op_b = '0;
    endcase
  end

  // Stage 2: floor shift, accumulate, saturate.
  assign shifted = prod >>> FRAC_BITS;
  assign acc_sum = (s2.first ? 66'sd0 : acc) + shifted;
  always_comb begin
    if (acc_sum > MAX32) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (acc_sum < MIN32) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= ctrl.mac;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1.valid) begin
      prod <= op_a * op_b;
    end
    if (s2.valid) begin
      unique case (s2.dst)
        vtv_pkg::DST_PRD: acc <= acc_sum;
        vtv_pkg::DST_VEC: acc <= acc_sum;
        vtv_pkg::DST_PH:  ph  <= prod;
        vtv_pkg::DST_PL:  pl  <= prod;
        default: ;
      endcase
    end
  end

  // Screen offset: exact product over 2^(2F+1), clamped.
  assign off_x  = (SUM_W'(ph) << vtv_pkg::MS_SPLIT) + SUM_W'(pl);
  assign q_full = off_x >> OFF_K;
  assign off_t  = neg[ctrl.coord] ? -$signed({1'b0, off_q}) : $signed({1'b0, off_q});
  assign scr_sum = $signed({{7{org[ctrl.coord][15]}}, org[ctrl.coord]})
                 + $signed({off_t[vtv_pkg::OFF_W], off_t});
  always_comb begin
    if (scr_sum > 23'sd32767) begin
      scr_sat = 16'sh7FFF;
    end else if (scr_sum < -23'sd32768) begin
      scr_sat = 16'sh8000;
    end else begin
      scr_sat = scr_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scr_sum) begin
      if (q_full > SUM_W'(vtv_pkg::OFF_LIMIT)) begin
        off_q <= vtv_pkg::OFF_W'(vtv_pkg::OFF_LIMIT);
      end else begin
        off_q <= q_full[vtv_pkg::OFF_W-1:0];
      end
    end
  end

  assign clip_w    = vec[7];
  assign div_num_s = vec[3'd4 + {1'b0, ctrl.div_sel}];
  assign div_num_m = div_num_s[31] ? 32'(-div_num_s) : div_num_s;
  assign div_den_m = clip_w[31] ? 32'(-clip_w) : clip_w;

  vtv_div #(.NUM_W(DIV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.div_start),
    .num   (DIV_W'(div_num_m) << FRAC_BITS),
    .den   (div_den_m),
    .neg   (div_num_s[31] ^ clip_w[31]),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      for (int i = 0; i < 8; i++) begin
        vec[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        ndc[i] <= '0;
      end
      scr[0] <= '0;
      scr[1] <= '0;
      wz     <= 1'b0;
    end else begin
      if (s2.valid && s2.last && (s2.dst == vtv_pkg::DST_VEC)) begin
        vec[s2.idx[2:0]] <= acc_sat;
      end
      if (ctrl.ndc_wr) begin
        ndc[ctrl.div_sel] <= div_quo;
      end
      if (ctrl.scr_fin) begin
        scr[ctrl.coord] <= scr_sat;
      end
      if (ctrl.set_wz) begin
        wz <= 1'b1;
      end
    end
  end

  assign status.w_zero   = (clip_w == 32'sd0);
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      eye_x    <= vec[0];
      eye_y    <= vec[1];
      eye_z    <= vec[2];
      eye_w    <= vec[3];
      ndc_x    <= ndc[0];
      ndc_y    <= ndc[1];
      ndc_z    <= ndc[2];
      screen_x <= scr[0];
      screen_y <= scr[1];
      w_zero   <= wz;
    end
  end

endmodule

[rtl/vtv_ctrl.sv]
module vtv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       command,
  input  logic [1:0]       matrix_id,
  output logic             out_valid,
  input  logic             out_stall,
  input  vtv_pkg::status_t status,
  output vtv_pkg::ctrl_t   ctrl
);

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_LOAD    = 12'b0000_0000_0100,
    S_MV      = 12'b0000_0000_1000,
    S_GAP     = 12'b0000_0001_0000,
    S_MVP     = 12'b0000_0010_0000,
    S_VTX     = 12'b0000_0100_0000,
    S_DRAIN   = 12'b0000_1000_0000,
    S_DIVGO   = 12'b0001_0000_0000,
    S_DIVWAIT = 12'b0010_0000_0000,
    S_SCR     = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [1:0] j, j_next;
  logic       coord, coord_next;
  logic       is_vtx, is_vtx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      j         <= '0;
      coord     <= 1'b0;
      is_vtx    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      j         <= j_next;
      coord     <= coord_next;
      is_vtx    <= is_vtx_next;
      out_valid <= ctrl.out_load | (out_valid & out_stall);
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    j_next      = j;
    coord_next  = coord;
    is_vtx_next = is_vtx;
    ctrl        = '0;
    ctrl.coord  = coord;
    ctrl.div_sel = j;

    unique case (state)
      S_CLEAR: begin
        ctrl.clr_we   = 1'b1;
        ctrl.clr_addr = cnt;
        cnt_next      = cnt + 1'b1;
        if (cnt == 6'd47) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctrl.take   = 1'b1;
          cnt_next    = '0;
          is_vtx_next = 1'b0;
          unique case (command)
            vtv_pkg::CMD_LOAD:
              state_next = (matrix_id == vtv_pkg::MAT_NONE) ? S_DONE : S_LOAD;
            vtv_pkg::CMD_COMBINE:
              state_next = S_MV;
            vtv_pkg::CMD_VERTEX: begin
              is_vtx_next = 1'b1;
              state_next  = S_VTX;
            end
            default:
              state_next = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        ctrl.src_load = 1'b1;
        state_next    = S_DONE;
      end
      S_MV: begin
        // modelview[r][c] += view[r][k] * model[k][c]
        ctrl.mac.valid = 1'b1;
        ctrl.mac.opa   = vtv_pkg::OPA_SRC;
        ctrl.mac.opb   = vtv_pkg::OPB_SRC;
        ctrl.mac.first = (cnt[1:0] == 2'd0);
        ctrl.mac.last  = (cnt[1:0] == 2'd3);
        ctrl.mac.dst   = vtv_pkg::DST_PRD;
        ctrl.mac.idx   = {1'b0, cnt[5:4], cnt[3:2]};
        ctrl.ra0       = {2'b01, cnt[5:4], cnt[1:0]};
        ctrl.ra1       = {2'b00, cnt[1:0], cnt[3:2]};
        cnt_next       = cnt + 1'b1;
        if (cnt == 6'd63) begin
          cnt_next   = '0;
          state_next = S_GAP;
        end
      end
      S_GAP: begin
        // Let the last modelview writes land before they are read back.
        cnt_next = cnt + 1'b1;
        if (cnt == 6'd2) begin
          cnt_next   = '0;
          state_next = S_MVP;
        end
      end
      S_MVP: begin
        ctrl.mac.valid = 1'b1;
        ctrl.mac.opa   = vtv_pkg::OPA_SRC;
        ctrl.mac.opb   = vtv_pkg::OPB_PRD;
        ctrl.mac.first = (cnt[1:0] == 2'd0);
        ctrl.mac.last  = (cnt[1:0] == 2'd3);
        ctrl.mac.dst   = vtv_pkg::DST_PRD;
        ctrl.mac.idx   = {1'b1, cnt[5:4], cnt[3:2]};
        ctrl.ra0       = {2'b10, cnt[5:4], cnt[1:0]};
        ctrl.ra1       = {2'b00, cnt[1:0], cnt[3:2]};
        cnt_next       = cnt + 1'b1;
        if (cnt == 6'd63) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end
      end
      S_VTX: begin
        // Eye rows first, then clip rows, four products per row.
        ctrl.mac.valid = 1'b1;
        ctrl.mac.opa   = vtv_pkg::OPA_PRD;
        ctrl.mac.opb   = vtv_pkg::OPB_POS;
        ctrl.mac.first = (cnt[1:0] == 2'd0);
        ctrl.mac.last  = (cnt[1:0] == 2'd3);
        ctrl.mac.dst   = vtv_pkg::DST_VEC;
        ctrl.mac.idx   = {2'b00, cnt[4:2]};
        ctrl.mac.k     = cnt[1:0];
        ctrl.ra0       = {1'b0, cnt[4:0]};
        cnt_next       = cnt + 1'b1;
        if (cnt == 6'd31) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == 6'd2) begin
          cnt_next   = '0;
          j_next     = '0;
          state_next = is_vtx ? S_DIVGO : S_DONE;
        end
      end
      S_DIVGO: begin
        if (status.w_zero) begin
          ctrl.set_wz = 1'b1;
          state_next  = S_DONE;
        end else begin
          ctrl.div_start = 1'b1;
          state_next     = S_DIVWAIT;
        end
      end
      S_DIVWAIT: begin
        if (status.div_done) begin
          ctrl.ndc_wr = 1'b1;
          if (j == 2'd2) begin
            cnt_next   = '0;
            coord_next = 1'b0;
            state_next = S_SCR;
          end else begin
            j_next     = j + 1'b1;
            state_next = S_DIVGO;
          end
        end
      end
      S_SCR: begin
        // Two partial products of the scale go through the multiply pipeline,
        // then the clamp and the origin add.
        cnt_next = cnt + 1'b1;
        unique case (cnt[2:0])
          3'd0: begin
            ctrl.mac.valid = 1'b1;
            ctrl.mac.opa   = vtv_pkg::OPA_MAG;
            ctrl.mac.opb   = vtv_pkg::OPB_MSHI;
            ctrl.mac.dst   = vtv_pkg::DST_PH;
            ctrl.mac.k     = {1'b0, coord};
          end
          3'd1: begin
            ctrl.mac.valid = 1'b1;
            ctrl.mac.opa   = vtv_pkg::OPA_MAG;
            ctrl.mac.opb   = vtv_pkg::OPB_MSLO;
            ctrl.mac.dst   = vtv_pkg::DST_PL;
            ctrl.mac.k     = {1'b0, coord};
          end
          3'd4: ctrl.scr_sum = 1'b1;
          3'd5: begin
            ctrl.scr_fin = 1'b1;
            cnt_next     = '0;
            if (coord) begin
              state_next = S_DONE;
            end else begin
              coord_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/vertex_transform_viewport_core.sv]
// Channel   Handshake             Payload
// input     in_valid / in_stall   command, matrix_id, coef_index, coef_value, pos_x..pos_w
// output    out_valid / out_stall eye_x..eye_w, ndc_x..ndc_z, screen_x, screen_y, w_zero
// config    cfg_write             cfg_index, cfg_data
//
// One item at a time. A combine runs 128 multiply-accumulates on one shared multiplier.
// A vertex runs 32 multiply-accumulates and, unless its clip w is zero, three bit-serial
// divides of 32 + FRAC_BITS steps each and two screen products per coordinate.
// After reset the matrix memories are cleared before the first item.
// A finished result waits in the output register while the next item is taken.
module vertex_transform_viewport_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [1:0]         matrix_id,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] pos_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] eye_x,
  output logic signed [31:0] eye_y,
  output logic signed [31:0] eye_z,
  output logic signed [31:0] eye_w,
  output logic signed [31:0] ndc_x,
  output logic signed [31:0] ndc_y,
  output logic signed [31:0] ndc_z,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic               w_zero
);

  vtv_pkg::ctrl_t   ctrl;
  vtv_pkg::status_t status;

  vtv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .matrix_id (matrix_id),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .ctrl      (ctrl)
  );

  vtv_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .matrix_id  (matrix_id),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .pos_w      (pos_w),
    .ctrl       (ctrl),
    .status     (status),
    .eye_x      (eye_x),
    .eye_y      (eye_y),
    .eye_z      (eye_z),
    .eye_w      (eye_w),
    .ndc_x      (ndc_x),
    .ndc_y      (ndc_y),
    .ndc_z      (ndc_z),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .w_zero     (w_zero)
  );

endmodule

[rtl/vtv_checker.sv]
module vtv_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] ndc_x,
  input logic signed [31:0] ndc_y,
  input logic signed [31:0] ndc_z,
  input logic signed [15:0] screen_x,
  input logic signed [15:0] screen_y,
  input logic               w_zero
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // The block works on one item at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while busy");

  // A zero clip w leaves device and screen fields at zero.
  a_wzero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> (ndc_x == 0 && ndc_y == 0 && ndc_z == 0 &&
                             screen_x == 0 && screen_y == 0))
    else $error("device or screen field set with zero w");

  // The memory clear runs after reset before any item is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input open right after reset");

endmodule

bind vertex_transform_viewport_core vtv_checker u_vtv_checker (.*);

[bench/testbench.sv]
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;
  localparam int SETTLE_CYCLES = 250;
  localparam int STALL_LIMIT = 6000;

  typedef struct {
    logic [1:0]         cmd;
    logic [1:0]         mid;
    logic [3:0]         cidx;
    logic signed [31:0] coef;
    logic signed [31:0] pos[4];
  } geo_item_t;

  typedef struct {
    logic signed [31:0] eye[4];
    logic signed [31:0] ndc[3];
    logic signed [15:0] scr_x;
    logic signed [15:0] scr_y;
    logic               wz;
  } geo_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = '0;
  logic [1:0]         matrix_id = '0;
  logic [3:0]         coef_index = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic signed [31:0] pos_w = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] eye_x, eye_y, eye_z, eye_w;
  logic signed [31:0] ndc_x, ndc_y, ndc_z;
  logic signed [15:0] screen_x, screen_y;
  logic               w_zero;

  vertex_transform_viewport_core dut (.*);

  always #2 clk = ~clk;

  // Predictor state: source matrices, the two products and the viewport registers.
  logic signed [31:0] src_mat[3][16];
  logic signed [31:0] mv_mat[16];
  logic signed [31:0] mvp_mat[16];
  logic [15:0]        view_reg[5];

  geo_result_t pending_results[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Q product, shifted down rounding toward minus infinity.
  function automatic longint q_mul(logic signed [31:0] a, longint b);
    longint p;
    p = longint'(a) * b;
    return p >>> FRAC;
  endfunction

  function automatic void combine_products();
    logic signed [31:0] tmp[16];
    longint acc;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += q_mul(src_mat[1][r*4+k], longint'(src_mat[0][k*4+c]));
        tmp[r*4+c] = sat32(acc);
      end
    mv_mat = tmp;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += q_mul(src_mat[2][r*4+k], longint'(mv_mat[k*4+c]));
        tmp[r*4+c] = sat32(acc);
      end
    mvp_mat = tmp;
  endfunction

  function automatic logic signed [15:0] map_screen(logic signed [31:0] ndc,
                                                    logic [15:0] origin, logic [15:0] size);
    longint a, s, t, sum;
    longint unsigned ma, ms, ph, pl, q;
    a = longint'(ndc) + ONE;
    s = longint'(size) * ONE - longint'(view_reg[vtv_pkg::CFG_EPS]);
    ma = (a < 0) ? -a : a;
    ms = (s < 0) ? -s : s;
    ph = ma * (ms >> vtv_pkg::MS_SPLIT);
    pl = ma * (ms & 64'hFFFFF);
    q = (ph + (pl >> vtv_pkg::MS_SPLIT)) >> (2 * FRAC + 1 - vtv_pkg::MS_SPLIT);
    if (q > vtv_pkg::OFF_LIMIT) q = vtv_pkg::OFF_LIMIT;
    t = ((a < 0) != (s < 0)) ? -longint'(q) : longint'(q);
    sum = longint'($signed(origin)) + t;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return sum[15:0];
  endfunction

  function automatic geo_result_t transform_item(geo_item_t it);
    geo_result_t r;
    logic signed [31:0] clip[4];
    longint acc;
    r.eye = '{default: '0};
    r.ndc = '{default: '0};
    r.scr_x = '0;
    r.scr_y = '0;
    r.wz = 1'b0;
    if (it.cmd == vtv_pkg::CMD_LOAD) begin
      if (it.mid != vtv_pkg::MAT_NONE) src_mat[it.mid][it.cidx] = it.coef;
    end else if (it.cmd == vtv_pkg::CMD_COMBINE) begin
      combine_products();
    end else if (it.cmd == vtv_pkg::CMD_VERTEX) begin
      for (int row = 0; row < 4; row++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += q_mul(mv_mat[row*4+k], longint'(it.pos[k]));
        r.eye[row] = sat32(acc);
        acc = 0;
        for (int k = 0; k < 4; k++) acc += q_mul(mvp_mat[row*4+k], longint'(it.pos[k]));
        clip[row] = sat32(acc);
      end
      if (clip[3] == 0) begin
        r.wz = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++)
          r.ndc[i] = sat32((longint'(clip[i]) * ONE) / longint'(clip[3]));
        r.scr_x = map_screen(r.ndc[0], view_reg[vtv_pkg::CFG_ORG_X],
                             view_reg[vtv_pkg::CFG_SIZE_W]);
        r.scr_y = map_screen(r.ndc[1], view_reg[vtv_pkg::CFG_ORG_Y],
                             view_reg[vtv_pkg::CFG_SIZE_H]);
      end
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Sends one item. Valid is left high after acceptance so that a following item
  // with no gap keeps it up; anything that waits drops it first.
  task automatic send_item(geo_item_t it);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= it.cmd;
    matrix_id <= it.mid;
    coef_index <= it.cidx;
    coef_value <= it.coef;
    pos_x <= it.pos[0];
    pos_y <= it.pos[1];
    pos_z <= it.pos[2];
    pos_w <= it.pos[3];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(transform_item(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [15:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    view_reg[index] = value;
  endtask

  task automatic set_viewport(logic [15:0] ox, logic [15:0] oy, logic [15:0] w,
                              logic [15:0] h, logic [15:0] eps);
    write_reg(vtv_pkg::CFG_ORG_X, ox);
    write_reg(vtv_pkg::CFG_ORG_Y, oy);
    write_reg(vtv_pkg::CFG_SIZE_W, w);
    write_reg(vtv_pkg::CFG_SIZE_H, h);
    write_reg(vtv_pkg::CFG_EPS, eps);
  endtask

  function automatic geo_item_t make_item(logic [1:0] cmd,
                                          logic [1:0] mid = vtv_pkg::MAT_NONE,
                                          logic [3:0] cidx = '0,
                                          logic signed [31:0] coef = '0);
    geo_item_t it;
    it.cmd = cmd;
    it.mid = mid;
    it.cidx = cidx;
    it.coef = coef;
    it.pos = '{default: '0};
    return it;
  endfunction

  task automatic send_load(logic [1:0] mid, logic [3:0] cidx, logic signed [31:0] coef);
    send_item(make_item(vtv_pkg::CMD_LOAD, mid, cidx, coef));
  endtask

  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic signed [31:0] w);
    geo_item_t it;
    it = make_item(vtv_pkg::CMD_VERTEX);
    it.pos = '{x, y, z, w};
    send_item(it);
  endtask

  function automatic logic signed [31:0] rand_q(int span_bits);
    return $signed($urandom_range(0, (1 << span_bits) - 1)) - (32'sd1 <<< (span_bits - 1));
  endfunction

  function automatic logic signed [31:0] rand_word();
    return $signed($urandom());
  endfunction

  // Fills a matrix with a diagonal near one plus small off-diagonal terms.
  task automatic load_matrix(logic [1:0] mid, int span_bits);
    for (int i = 0; i < 16; i++) begin
      if (i % 5 == 0) send_load(mid, i[3:0], 32'sd65536 + rand_q(span_bits));
      else send_load(mid, i[3:0], rand_q(span_bits));
    end
  endtask

  task automatic test_directed();
    // Diagonal loads give identity-like sources; the projection makes w depend on z.
    send_load(0, 0, 32'sh0002_0000);
    send_load(0, 5, 32'sh0001_0000);
    send_load(0, 10, 32'sh0001_0000);
    send_load(0, 15, 32'sh0001_0000);
    send_load(1, 0, 32'sh0001_0000);
    send_load(1, 5, 32'sh0001_0000);
    send_load(1, 10, 32'sh0001_0000);
    send_load(1, 15, 32'sh0001_0000);
    send_load(2, 0, 32'sh0001_0000);
    send_load(2, 5, 32'sh0001_0000);
    send_load(2, 10, 32'sh0001_0000);
    send_load(2, 15, 32'sh0001_0000);
    send_load(2, 14, 32'sh0000_8000);
    // A load to no matrix and an unused command must change nothing.
    send_load(vtv_pkg::MAT_NONE, 15, 32'sh7fffffff);
    send_item(make_item(2'd3, 2'd1, 4'd15, 32'sh80000000));
    send_item(make_item(vtv_pkg::CMD_COMBINE));
    send_vertex(32'sh0000_8000, -32'sh0000_4000, 32'sh0001_0000, 32'sh0001_0000);
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh0000_0001);
    send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    // Clip w zero: flag set, device and screen outputs cleared.
    send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000);
    send_vertex(32'sh0003_0000, 32'sh0002_0000, -32'sh0002_0000, 32'sh0001_0000);
    send_load(1, 3, 32'sh80000000);
    send_load(0, 12, 32'sh7fffffff);
    send_item(make_item(vtv_pkg::CMD_COMBINE));
    send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
  endtask

  task automatic test_viewport_settings();
    load_matrix(0, 14);
    load_matrix(1, 14);
    load_matrix(2, 14);
    send_item(make_item(vtv_pkg::CMD_COMBINE));
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: set_viewport(16'd0, 16'd0, 16'd640, 16'd480, 16'd1);
        1: set_viewport(16'h8000, 16'h7fff, 16'hffff, 16'hffff, 16'd0);
        2: set_viewport(16'h7fff, 16'h8000, 16'd1, 16'd1, 16'hffff);
        3: set_viewport(16'hff00, 16'h0100, 16'd1, 16'd2, 16'h8000);
        4: set_viewport(16'h1234, 16'hedcb, 16'd1920, 16'd1080, 16'h5555);
        default: set_viewport(16'hffff, 16'h0000, 16'd800, 16'd600, 16'haaaa);
      endcase
      calm = (s == 4);
      for (int n = 0; n < 10; n++)
        send_vertex(rand_q(20), rand_q(20), rand_q(20), 32'sh0001_0000 + rand_q(16));
      send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh0000_0100);
      send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh0000_0100);
      calm = 1'b0;
    end
  endtask

  task automatic test_random_scenes();
    geo_item_t it;
    int sent;
    sent = 0;
    while (sent < 250) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) begin
        // A well-formed scene: a few coefficient updates, a combine, then vertices.
        for (int n = $urandom_range(1, 6); n > 0; n--) begin
          send_load(2'($urandom_range(0, 2)), 4'($urandom_range(0, 15)),
                    ($urandom_range(0, 7) == 0) ? rand_word() : rand_q(18));
          sent++;
        end
        send_item(make_item(vtv_pkg::CMD_COMBINE));
        sent++;
        for (int n = $urandom_range(2, 12); n > 0; n--) begin
          if ($urandom_range(0, 9) == 0)
            send_vertex(rand_word(), rand_word(), rand_word(), rand_word());
          else
            send_vertex(rand_q(22), rand_q(22), rand_q(22),
                        ($urandom_range(0, 9) == 0) ? 32'sd0 : 32'sh0001_0000 + rand_q(17));
          sent++;
        end
      end else begin
        // Noise: any bit pattern on every field.
        it.cmd = 2'($urandom_range(0, 3));
        it.mid = 2'($urandom_range(0, 3));
        it.cidx = 4'($urandom_range(0, 15));
        it.coef = rand_word();
        it.pos = '{rand_word(), rand_word(), rand_word(), rand_word()};
        send_item(it);
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // Result side: a random stall before each item, then the check.
  initial begin
    geo_result_t want;
    int w;
    @(negedge rst);
    forever begin
      w = draw_wait();
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (eye_x !== want.eye[0]) report("eye_x", eye_x, want.eye[0]);
        if (eye_y !== want.eye[1]) report("eye_y", eye_y, want.eye[1]);
        if (eye_z !== want.eye[2]) report("eye_z", eye_z, want.eye[2]);
        if (eye_w !== want.eye[3]) report("eye_w", eye_w, want.eye[3]);
        if (ndc_x !== want.ndc[0]) report("ndc_x", ndc_x, want.ndc[0]);
        if (ndc_y !== want.ndc[1]) report("ndc_y", ndc_y, want.ndc[1]);
        if (ndc_z !== want.ndc[2]) report("ndc_z", ndc_z, want.ndc[2]);
        if (screen_x !== want.scr_x) report("screen_x", screen_x, want.scr_x);
        if (screen_y !== want.scr_y) report("screen_y", screen_y, want.scr_y);
        if (w_zero !== want.wz) report("w_zero", w_zero, want.wz);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[vertex_transform_viewport_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    src_mat = '{default: '{default: '0}};
    mv_mat = '{default: '0};
    mvp_mat = '{default: '0};
    view_reg = '{16'd0, 16'd0, 16'd1, 16'd1, 16'd1};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_viewport_settings();
    test_random_scenes();
    drain();
    if (error_count == 0) begin
      $display("[vertex_transform_viewport_core] OK");
    end else begin
      $display("[vertex_transform_viewport_core] ERROR");
    end
    $finish;
  end

endmodule
